/* hw/rtl/degenerate_triangle_filter_macros.svh */
// Assertion macros for the degenerate triangle filter.
`ifndef DEGENERATE_TRIANGLE_FILTER_MACROS_SVH
`define DEGENERATE_TRIANGLE_FILTER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define DTF_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

`define DTF_ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define DTF_ASSERT(label, clk, rst_n, prop)

`define DTF_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

/* hw/rtl/dtf_pkg.sv */
// Types, widths and helpers shared by the degenerate triangle filter.
`timescale 1ns / 1ps
`default_nettype none
package dtf_pkg;

	localparam int CoordW          = 16;             // input coordinate, signed Q8.8
	localparam int ScaleW          = 16;             // scale factor, unsigned Q4.12
	localparam int ThrW            = 40;             // area and edge thresholds
	localparam int OutW            = 20;             // scaled coordinate, signed Q12.8
	localparam int EdgeW           = OutW + 1;       // signed edge component
	localparam int MagW            = OutW;           // edge component magnitude
	localparam int SqW             = 2 * MagW;       // squared edge component
	localparam int LenW            = SqW + 2;        // squared edge length
	localparam int CrossW          = 2 * EdgeW;      // cross product term and component
	localparam int SmallW          = 21;             // cross magnitude worth squaring
	localparam int CrSqW           = 2 * SmallW;     // squared cross component
	localparam int AreaW           = CrSqW + 2;      // sum of squared cross components
	localparam int AspW            = LenW + ScaleW;  // max_aspect * shortest
	localparam int CfgIdxW         = 3;
	localparam int CfgDataW        = ThrW;
	localparam int ScaleFracBitsDef = 12;

	localparam logic [ScaleW-1:0] ScaleReset   = 16'd4096;
	localparam logic [ThrW-1:0]   MinAreaReset = 40'd1;
	localparam logic [ThrW-1:0]   MinEdgeReset = 40'd1;
	localparam logic [ScaleW-1:0] AspectReset  = 16'd10000;

	typedef enum logic [CfgIdxW-1:0] {
		RegScaleX    = 3'd0,
		RegScaleY    = 3'd1,
		RegScaleZ    = 3'd2,
		RegMinArea   = 3'd3,
		RegMinEdge   = 3'd4,
		RegMaxAspect = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		ReasonKept   = 2'd0,
		ReasonArea   = 2'd1,
		ReasonSkinny = 2'd2
	} reason_t;

	typedef struct packed {
		logic signed [CoordW-1:0] ax;
		logic signed [CoordW-1:0] ay;
		logic signed [CoordW-1:0] az;
		logic signed [CoordW-1:0] bx;
		logic signed [CoordW-1:0] by;
		logic signed [CoordW-1:0] bz;
		logic signed [CoordW-1:0] cx;
		logic signed [CoordW-1:0] cy;
		logic signed [CoordW-1:0] cz;
	} tri_word_t;

	typedef struct packed {
		logic signed [OutW-1:0] sax;
		logic signed [OutW-1:0] say;
		logic signed [OutW-1:0] saz;
		logic signed [OutW-1:0] sbx;
		logic signed [OutW-1:0] sby;
		logic signed [OutW-1:0] sbz;
		logic signed [OutW-1:0] scx;
		logic signed [OutW-1:0] scy;
		logic signed [OutW-1:0] scz;
		logic                   kept;
		logic [1:0]             reject_reason;
	} res_word_t;

	// [vertex][axis], vertex 0..2 = A..C, axis 0..2 = x..z
	typedef logic [2:0][2:0][OutW-1:0] tri_coords_t;

	typedef struct packed {
		tri_coords_t               coords;
		logic [2:0][CrSqW-1:0]     crsq;
		logic                      big;
		logic [LenW-1:0]           lmin;
		logic [LenW-1:0]           lmax;
	} geom_word_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} pipe_en_t;

	// b - a with one guard bit
	function automatic logic signed [EdgeW-1:0] edge_diff(logic [OutW-1:0] a,
			logic [OutW-1:0] b);
		edge_diff = $signed({b[OutW-1], b}) - $signed({a[OutW-1], a});
	endfunction

	function automatic logic [MagW-1:0] edge_mag(logic signed [EdgeW-1:0] d);
		logic signed [EdgeW-1:0] n;
		n = -d;
		edge_mag = d[EdgeW-1] ? n[MagW-1:0] : d[MagW-1:0];
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/dtf_scale.sv */
// Stage 1: per-axis scaling of the nine coordinates to signed Q12.8.
`timescale 1ns / 1ps
`default_nettype none
module dtf_scale import dtf_pkg::*; #(
	parameter int SCALE_FRAC_BITS = ScaleFracBitsDef
) (
	input  logic              clk,
	input  pipe_en_t          en,
	input  tri_word_t         tri_word,
	input  logic [ScaleW-1:0] scale_x,
	input  logic [ScaleW-1:0] scale_y,
	input  logic [ScaleW-1:0] scale_z,
	output tri_coords_t       coords_s1
);

	localparam int ProdW = CoordW + ScaleW + 1;

	logic [2:0][2:0][CoordW-1:0] raw;
	logic [2:0][ScaleW-1:0]      sc;
	logic signed [ProdW-1:0]     prod [3][3];
	tri_coords_t                 scaled;

	always_comb begin
		raw[0] = {tri_word.az, tri_word.ay, tri_word.ax};
		raw[1] = {tri_word.bz, tri_word.by, tri_word.bx};
		raw[2] = {tri_word.cz, tri_word.cy, tri_word.cx};
		sc     = {scale_z, scale_y, scale_x};
	end

	// arithmetic shift floors toward minus infinity; wrap to the output width
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 3; i++) begin
				prod[k][i] = $signed(raw[k][i]) * $signed({1'b0, sc[i]});
				scaled[k][i] = OutW'(prod[k][i] >>> SCALE_FRAC_BITS);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			coords_s1 <= scaled;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/dtf_geom.sv */
// Stages 2 to 4: edges, cross product and squared edge lengths.
`timescale 1ns / 1ps
`default_nettype none
module dtf_geom import dtf_pkg::*; (
	input  logic        clk,
	input  pipe_en_t    en,
	input  tri_coords_t coords_s1,
	output geom_word_t  geom_s4
);

	// stage 2: edge vectors, cross terms and squared edge components
	logic signed [EdgeW-1:0] e1 [3];   // B - A
	logic signed [EdgeW-1:0] e2 [3];   // C - A
	logic signed [EdgeW-1:0] e3 [3];   // C - B
	logic [MagW-1:0]         m [3][3]; // edges AB, BC, CA

	logic signed [CrossW-1:0] prod_s2 [6];
	logic [SqW-1:0]           esq_s2 [3][3];
	tri_coords_t              coords_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			e1[i] = edge_diff(coords_s1[0][i], coords_s1[1][i]);
			e2[i] = edge_diff(coords_s1[0][i], coords_s1[2][i]);
			e3[i] = edge_diff(coords_s1[1][i], coords_s1[2][i]);
			m[0][i] = edge_mag(e1[i]);
			m[1][i] = edge_mag(e3[i]);
			m[2][i] = edge_mag(e2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_s2[0] <= e1[1] * e2[2];
			prod_s2[1] <= e1[2] * e2[1];
			prod_s2[2] <= e1[2] * e2[0];
			prod_s2[3] <= e1[0] * e2[2];
			prod_s2[4] <= e1[0] * e2[1];
			prod_s2[5] <= e1[1] * e2[0];
			for (int j = 0; j < 3; j++) begin
				for (int i = 0; i < 3; i++) begin
					esq_s2[j][i] <= m[j][i] * m[j][i];
				end
			end
			coords_s2 <= coords_s1;
		end
	end

	// stage 3: cross components, magnitude check, edge length sums
	logic signed [CrossW-1:0] cr [3];
	logic [CrossW-1:0]        crmag [3];
	logic [2:0]               wide;

	logic [SmallW-1:0] crm_s3 [3];
	logic              big_s3;
	logic [LenW-1:0]   len_s3 [3];
	tri_coords_t       coords_s3;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			cr[j]    = prod_s2[2 * j] - prod_s2[2 * j + 1];
			crmag[j] = cr[j][CrossW-1] ? CrossW'(-cr[j]) : CrossW'(cr[j]);
			// a component of 2^21 or more alone exceeds any area threshold
			wide[j]  = |crmag[j][CrossW-1:SmallW];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			for (int j = 0; j < 3; j++) begin
				crm_s3[j] <= crmag[j][SmallW-1:0];
				len_s3[j] <= LenW'(esq_s2[j][0]) + LenW'(esq_s2[j][1])
					+ LenW'(esq_s2[j][2]);
			end
			big_s3    <= |wide;
			coords_s3 <= coords_s2;
		end
	end

	// stage 4: squared cross components, shortest and longest edge
	logic [LenW-1:0] lo01, hi01;

	always_comb begin
		lo01 = (len_s3[1] < len_s3[0]) ? len_s3[1] : len_s3[0];
		hi01 = (len_s3[1] > len_s3[0]) ? len_s3[1] : len_s3[0];
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			for (int j = 0; j < 3; j++) begin
				geom_s4.crsq[j] <= crm_s3[j] * crm_s3[j];
			end
			geom_s4.big    <= big_s3;
			geom_s4.lmin   <= (len_s3[2] < lo01) ? len_s3[2] : lo01;
			geom_s4.lmax   <= (len_s3[2] > hi01) ? len_s3[2] : hi01;
			geom_s4.coords <= coords_s3;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/dtf_test.sv */
// Stages 5 and 6: area and aspect tests, result word register.
`timescale 1ns / 1ps
`default_nettype none
module dtf_test import dtf_pkg::*; (
	input  logic              clk,
	input  pipe_en_t          en,
	input  geom_word_t        geom_s4,
	input  logic [ThrW-1:0]   min_area_sq,
	input  logic [ThrW-1:0]   min_edge_sq,
	input  logic [ScaleW-1:0] max_aspect,
	output res_word_t         res_s6
);

	// stage 5
	logic [AreaW-1:0] cross_sum;
	logic [AreaW-1:0] area_thr;

	logic             area_fail_s5;
	logic             edge_fail_s5;
	logic [AspW-1:0]  aspect_s5;
	logic [LenW-1:0]  lmax_s5;
	tri_coords_t      coords_s5;

	always_comb begin
		cross_sum = AreaW'(geom_s4.crsq[0]) + AreaW'(geom_s4.crsq[1])
			+ AreaW'(geom_s4.crsq[2]);
		// quarter area test: cross_len_sq < 4 * min_area_sq
		area_thr  = AreaW'({min_area_sq, 2'b00});
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			area_fail_s5 <= !geom_s4.big && (cross_sum < area_thr);
			edge_fail_s5 <= geom_s4.lmin < LenW'(min_edge_sq);
			aspect_s5    <= AspW'(max_aspect) * AspW'(geom_s4.lmin);
			lmax_s5      <= geom_s4.lmax;
			coords_s5    <= geom_s4.coords;
		end
	end

	// stage 6
	logic    skinny;
	reason_t reason;

	always_comb begin
		skinny = edge_fail_s5 || (AspW'(lmax_s5) > aspect_s5);
		if (area_fail_s5) begin
			reason = ReasonArea;
		end else if (skinny) begin
			reason = ReasonSkinny;
		end else begin
			reason = ReasonKept;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			res_s6.sax           <= coords_s5[0][0];
			res_s6.say           <= coords_s5[0][1];
			res_s6.saz           <= coords_s5[0][2];
			res_s6.sbx           <= coords_s5[1][0];
			res_s6.sby           <= coords_s5[1][1];
			res_s6.sbz           <= coords_s5[1][2];
			res_s6.scx           <= coords_s5[2][0];
			res_s6.scy           <= coords_s5[2][1];
			res_s6.scz           <= coords_s5[2][2];
			res_s6.kept          <= (reason == ReasonKept);
			res_s6.reject_reason <= reason;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/degenerate_triangle_filter.sv */
// Top level of the degenerate triangle filter: config registers and pipeline control.
// Usage:
//   Triangles enter on tri_valid/tri_ready/tri_word, one word per triangle: nine
//   signed Q8.8 coordinates. Each leaves on res_valid/res_ready/res_word as the
//   scaled Q12.8 vertices plus kept and reject_reason (0 kept, 1 area too small,
//   2 too skinny). Rejected triangles still come out, in input order.
//   A triangle passes through the stages in order: scale multiply, edge and cross
//   multiplies, cross and length sums, cross squares and min/max, area and aspect
//   compare, result register; res_valid rises when the word reaches the last one.
//   Throughput is one triangle per cycle while the output is not stalled; every
//   stage holds its own valid bit.
//   When the receiver holds res_ready low the last stage keeps its word and
//   earlier stages keep filling empty slots; tri_ready drops only when all
//   six stages are full.
//   Registers are written through cfg_we/cfg_index/cfg_data, one per cycle; the user
//   must write them only while no triangle is in flight, the block does not enforce it.
//   arst_n clears all stage valid bits and loads the register defaults:
//   unit scales, both thresholds 1, aspect limit 10000.
`timescale 1ns / 1ps
`default_nettype none
`include "degenerate_triangle_filter_macros.svh"
module degenerate_triangle_filter import dtf_pkg::*; #(
	parameter int SCALE_FRAC_BITS = ScaleFracBitsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tri_valid,
	output logic                tri_ready,
	input  tri_word_t           tri_word,
	output logic                res_valid,
	input  logic                res_ready,
	output res_word_t           res_word,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	logic [ScaleW-1:0] scale_x_q, scale_y_q, scale_z_q, max_aspect_q;
	logic [ThrW-1:0]   min_area_q, min_edge_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q    <= ScaleReset;
			scale_y_q    <= ScaleReset;
			scale_z_q    <= ScaleReset;
			min_area_q   <= MinAreaReset;
			min_edge_q   <= MinEdgeReset;
			max_aspect_q <= AspectReset;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				RegScaleX:    scale_x_q    <= cfg_data[ScaleW-1:0];
				RegScaleY:    scale_y_q    <= cfg_data[ScaleW-1:0];
				RegScaleZ:    scale_z_q    <= cfg_data[ScaleW-1:0];
				RegMinArea:   min_area_q   <= cfg_data[ThrW-1:0];
				RegMinEdge:   min_edge_q   <= cfg_data[ThrW-1:0];
				RegMaxAspect: max_aspect_q <= cfg_data[ScaleW-1:0];
				default: ;
			endcase
		end
	end

	// stage enables: a stage loads when empty or when its word moves on
	pipe_en_t en;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;

	always_comb begin
		en.s6 = !valid_s6 || res_ready;
		en.s5 = !valid_s5 || en.s6;
		en.s4 = !valid_s4 || en.s5;
		en.s3 = !valid_s3 || en.s4;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= tri_valid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
			if (en.s5) valid_s5 <= valid_s4;
			if (en.s6) valid_s6 <= valid_s5;
		end
	end

	assign tri_ready = en.s1;
	assign res_valid = valid_s6;

	tri_coords_t coords_s1;
	geom_word_t  geom_s4;

	dtf_scale #(
		.SCALE_FRAC_BITS(SCALE_FRAC_BITS)
	) u_scale (
		.clk       (clk),
		.en        (en),
		.tri_word  (tri_word),
		.scale_x   (scale_x_q),
		.scale_y   (scale_y_q),
		.scale_z   (scale_z_q),
		.coords_s1 (coords_s1)
	);

	dtf_geom u_geom (
		.clk       (clk),
		.en        (en),
		.coords_s1 (coords_s1),
		.geom_s4   (geom_s4)
	);

	dtf_test u_test (
		.clk         (clk),
		.en          (en),
		.geom_s4     (geom_s4),
		.min_area_sq (min_area_q),
		.min_edge_sq (min_edge_q),
		.max_aspect  (max_aspect_q),
		.res_s6      (res_word)
	);

	// backpressure reaches the input only through a completely full pipeline
	`DTF_ASSERT_NEVER(a_block_not_full, clk, arst_n, !tri_ready && !(valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5 && valid_s6))
	`DTF_ASSERT(a_accept_fills_s1, clk, arst_n, (tri_valid && tri_ready) |=> valid_s1)
	`DTF_ASSERT(a_kept_matches_reason, clk, arst_n, res_valid |-> (res_word.kept == (res_word.reject_reason == ReasonKept)))

endmodule
`default_nettype wire
